FILE: hw/rtl/crba_pkg.sv
// Shared types and constants for the colored run block allocator.
// Holds the request codes, result status codes and the sequencer state type.
// No dependencies.
package crba_pkg;

	localparam logic OP_ALLOC = 1'b0;
	localparam logic OP_FREE  = 1'b1;

	localparam logic [1:0] ST_OK       = 2'd0;
	localparam logic [1:0] ST_BAD_ARG  = 2'd1;
	localparam logic [1:0] ST_NO_SPACE = 2'd2;

	localparam logic [1:0] COLOR_FREE = 2'd0;

	typedef enum logic [3:0] {
		S_CLEAR,
		S_IDLE,
		S_SCAN,
		S_SCAN_END,
		S_EDGE_B,
		S_EDGE_A,
		S_COLOR,
		S_FILL,
		S_FR_RD,
		S_FR_PREV,
		S_FR_CHK,
		S_FREE
	} state_t;

endpackage

FILE: hw/rtl/crba_mem.sv
// Color map storage: one write port and one read port with registered read data.
// Standalone; no package dependencies.
module crba_mem #(
	parameter int DEPTH = 1024,
	parameter int AW    = 10
) (
	input  logic          clk,
	input  logic          we,
	input  logic [AW-1:0] waddr,
	input  logic [1:0]    wdata,
	input  logic [AW-1:0] raddr,
	output logic [1:0]    rdata
);

	logic [1:0] mem [DEPTH];
	logic [1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata_q <= mem[raddr];
	end

	assign rdata = rdata_q;

endmodule

FILE: hw/rtl/colored_run_block_allocator_top.sv
// Top level of the colored run block allocator: request sequencer and result register.
// Depends on crba_pkg and crba_mem.
//
//   Channel   Handshake                 Payload
//   in        in_valid / in_stall       op, block_count, block_index
//   out       out_valid / out_stall     status, start_index, run_length
//
// An allocate request scans the color map through its single read port, one entry per cycle,
// then reads the entries on either side of the first largest free run, picks a color unlike
// both and fills block_count entries from its start; it ends after the scan when no run fits.
// A free request reads the indexed entry and the one before it to check the index, then frees
// the run's blocks in turn, reading ahead until the run ends or reaches the last entry.
// A request with a zero or oversized count or an index outside the map is answered from idle.
// After reset a clearing pass zeroes the map; no request is taken then.
// One request is in flight at a time, and none is accepted while a result waits.
module colored_run_block_allocator_top #(
	parameter int ENTRIES = 1024
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic        op,
	input  logic [10:0] block_count,
	input  logic [9:0]  block_index,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [1:0]  status,
	output logic [9:0]  start_index,
	output logic [10:0] run_length
);

	import crba_pkg::*;

	localparam int AW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
	localparam int CW = $clog2(ENTRIES + 1);
	localparam int EW = AW + 1;
	localparam logic [AW-1:0] LAST = AW'(ENTRIES - 1);
	localparam logic [EW-1:0] ENT_E = EW'(ENTRIES);

	state_t state_q, state_d;

	logic [AW-1:0] ptr_q;
	logic [AW-1:0] scan_p_s1;
	logic          scan_v_s1;
	logic [CW-1:0] run_len_q, best_len_q, len_q, cnt_q;
	logic [AW-1:0] run_start_q, best_start_q;
	logic [1:0]    color_q, before_q;

	logic          out_valid_q;
	logic [1:0]    status_q;
	logic [AW-1:0] start_q;
	logic [CW-1:0] res_len_q;

	logic          mem_we;
	logic [AW-1:0] mem_waddr, mem_raddr;
	logic [1:0]    mem_wdata, rd_data;

	logic          accept;
	logic          alloc_bad, free_bad;
	logic [CW-1:0] run_len_n, best_len_n;
	logic [AW-1:0] run_start_n, best_start_n;
	logic [EW-1:0] end_e;
	logic [1:0]    after_c, color_c;
	logic          prev_same;

	crba_mem #(.DEPTH(ENTRIES), .AW(AW)) u_mem (
		.clk   (clk),
		.we    (mem_we),
		.waddr (mem_waddr),
		.wdata (mem_wdata),
		.raddr (mem_raddr),
		.rdata (rd_data)
	);

	assign accept    = in_valid && !in_stall;
	assign alloc_bad = (block_count == 11'd0) || (32'(block_count) > 32'(ENTRIES));
	assign free_bad  = 32'(block_index) >= 32'(ENTRIES);
	assign end_e     = EW'(best_start_q) + EW'(best_len_q);
	assign prev_same = (ptr_q != '0) && (rd_data == color_q);

	always_comb begin
		run_len_n    = run_len_q;
		run_start_n  = run_start_q;
		best_len_n   = best_len_q;
		best_start_n = best_start_q;
		if (scan_v_s1) begin
			if (rd_data != COLOR_FREE) begin
				run_len_n = '0;
			end else begin
				if (run_len_q == '0) begin
					run_start_n = scan_p_s1;
				end
				run_len_n = run_len_q + CW'(1);
				if (run_len_n > best_len_q) begin
					best_len_n   = run_len_n;
					best_start_n = run_start_n;
				end
			end
		end
	end

	always_comb begin
		after_c = (end_e < ENT_E) ? rd_data : COLOR_FREE;
		color_c = 2'd1;
		if (before_q == color_c || after_c == color_c) begin
			color_c = 2'd2;
		end
		if (before_q == color_c || after_c == color_c) begin
			color_c = 2'd3;
		end
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			S_CLEAR: begin
				if (ptr_q == LAST) begin
					state_d = S_IDLE;
				end
			end
			S_IDLE: begin
				if (accept) begin
					if (op == OP_ALLOC) begin
						state_d = alloc_bad ? S_IDLE : S_SCAN;
					end else begin
						state_d = free_bad ? S_IDLE : S_FR_RD;
					end
				end
			end
			S_SCAN: begin
				if (ptr_q == LAST) begin
					state_d = S_SCAN_END;
				end
			end
			S_SCAN_END: state_d = S_EDGE_B;
			S_EDGE_B:   state_d = (best_len_q < cnt_q) ? S_IDLE : S_EDGE_A;
			S_EDGE_A:   state_d = S_COLOR;
			S_COLOR:    state_d = S_FILL;
			S_FILL: begin
				if (len_q + CW'(1) == cnt_q) begin
					state_d = S_IDLE;
				end
			end
			S_FR_RD:   state_d = S_FR_PREV;
			S_FR_PREV: state_d = S_FR_CHK;
			S_FR_CHK: begin
				state_d = (color_q == COLOR_FREE || prev_same) ? S_IDLE : S_FREE;
			end
			S_FREE: begin
				if (rd_data != color_q || ptr_q == LAST) begin
					state_d = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_comb begin
		mem_we    = 1'b0;
		mem_waddr = ptr_q;
		mem_wdata = COLOR_FREE;
		mem_raddr = ptr_q;
		in_stall  = !(state_q == S_IDLE && !out_valid_q);
		case (state_q)
			S_CLEAR: mem_we = 1'b1;
			S_EDGE_B: mem_raddr = best_start_q - AW'(1);
			S_EDGE_A: mem_raddr = end_e[AW-1:0];
			S_FILL: begin
				mem_we    = 1'b1;
				mem_wdata = color_q;
			end
			S_FR_PREV: mem_raddr = ptr_q - AW'(1);
			S_FREE: begin
				mem_we    = (rd_data == color_q);
				mem_raddr = ptr_q + AW'(1);
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_CLEAR;
			ptr_q       <= '0;
			scan_v_s1   <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (out_valid_q && !out_stall) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				S_CLEAR: ptr_q <= ptr_q + AW'(1);
				S_IDLE: begin
					if (accept) begin
						if (op == OP_ALLOC) begin
							ptr_q <= '0;
							if (alloc_bad) begin
								out_valid_q <= 1'b1;
								status_q    <= ST_BAD_ARG;
								start_q     <= '0;
								res_len_q   <= '0;
							end
						end else begin
							ptr_q <= AW'(block_index);
							if (free_bad) begin
								out_valid_q <= 1'b1;
								status_q    <= ST_BAD_ARG;
								start_q     <= '0;
								res_len_q   <= '0;
							end
						end
					end
				end
				S_SCAN: begin
					scan_v_s1 <= 1'b1;
					ptr_q     <= ptr_q + AW'(1);
				end
				S_SCAN_END: scan_v_s1 <= 1'b0;
				S_EDGE_B: begin
					if (best_len_q < cnt_q) begin
						out_valid_q <= 1'b1;
						status_q    <= ST_NO_SPACE;
						start_q     <= '0;
						res_len_q   <= '0;
					end
				end
				S_EDGE_A: begin
					before_q <= (best_start_q != '0) ? rd_data : COLOR_FREE;
				end
				S_COLOR: begin
					color_q <= color_c;
					ptr_q   <= best_start_q;
				end
				S_FILL: begin
					ptr_q <= ptr_q + AW'(1);
					if (len_q + CW'(1) == cnt_q) begin
						out_valid_q <= 1'b1;
						status_q    <= ST_OK;
						start_q     <= best_start_q;
						res_len_q   <= cnt_q;
					end
				end
				S_FR_PREV: color_q <= rd_data;
				S_FR_CHK: begin
					if (color_q == COLOR_FREE || prev_same) begin
						out_valid_q <= 1'b1;
						status_q    <= ST_BAD_ARG;
						start_q     <= '0;
						res_len_q   <= '0;
					end
				end
				S_FREE: begin
					ptr_q <= ptr_q + AW'(1);
					if (rd_data != color_q) begin
						out_valid_q <= 1'b1;
						status_q    <= ST_OK;
						start_q     <= best_start_q;
						res_len_q   <= len_q;
					end else if (ptr_q == LAST) begin
						out_valid_q <= 1'b1;
						status_q    <= ST_OK;
						start_q     <= best_start_q;
						res_len_q   <= len_q + CW'(1);
					end
				end
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		scan_p_s1 <= ptr_q;
		case (state_q)
			S_IDLE: begin
				if (accept) begin
					run_len_q    <= '0;
					best_len_q   <= '0;
					best_start_q <= '0;
					cnt_q        <= CW'(block_count);
				end
			end
			S_SCAN, S_SCAN_END: begin
				run_len_q    <= run_len_n;
				run_start_q  <= run_start_n;
				best_len_q   <= best_len_n;
				best_start_q <= best_start_n;
			end
			S_COLOR: len_q <= '0;
			S_FILL:  len_q <= len_q + CW'(1);
			S_FR_CHK: begin
				len_q        <= '0;
				best_start_q <= ptr_q;
			end
			S_FREE: len_q <= len_q + CW'(1);
			default: ;
		endcase
	end

	assign out_valid   = out_valid_q;
	assign status      = status_q;
	assign start_index = 10'(start_q);
	assign run_length  = 11'(res_len_q);

endmodule

FILE: tb/colored_run_block_allocator_top_tb.sv
// Self-checking testbench for the colored run block allocator.
// Predicts every result from its own copy of the color map and checks the outputs.
// Depends on crba_pkg and colored_run_block_allocator_top.
module colored_run_block_allocator_top_tb;
	import crba_pkg::*;

	localparam int MAP_SIZE = 1024;
	localparam int WATCH_LIMIT = 60000;

	typedef struct packed {
		logic [1:0]  status;
		logic [9:0]  start_index;
		logic [10:0] run_length;
	} alloc_result_t;

	logic        clk;
	logic        arst_n;
	logic        in_valid;
	logic        in_stall;
	logic        op;
	logic [10:0] block_count;
	logic [9:0]  block_index;
	logic        out_valid;
	logic        out_stall;
	logic [1:0]  status;
	logic [9:0]  start_index;
	logic [10:0] run_length;

	logic [1:0] model_map [MAP_SIZE];
	alloc_result_t expected_results [$];
	int errors;
	int idle_cycles;
	bit hold_receiver;

	colored_run_block_allocator_top #(.ENTRIES(MAP_SIZE)) DUT (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_stall(in_stall),
		.op(op), .block_count(block_count), .block_index(block_index),
		.out_valid(out_valid), .out_stall(out_stall),
		.status(status), .start_index(start_index), .run_length(run_length)
	);

	always begin
		clk = 1'b0;
		#2;
		clk = 1'b1;
		#2;
	end

	function automatic alloc_result_t predict_allocate(int count);
		alloc_result_t r;
		int best_start, best_len, run_begin, run_len, run_end;
		logic [1:0] left, right, color;
		r = '0;
		best_start = 0;
		best_len = 0;
		run_begin = 0;
		run_len = 0;
		left = COLOR_FREE;
		right = COLOR_FREE;
		if (count == 0 || count > MAP_SIZE) begin
			r.status = ST_BAD_ARG;
			return r;
		end
		for (int i = 0; i < MAP_SIZE; i++) begin
			if (model_map[i] != COLOR_FREE) begin
				run_len = 0;
			end else begin
				if (run_len == 0)
					run_begin = i;
				run_len++;
				if (run_len > best_len) begin
					best_len = run_len;
					best_start = run_begin;
				end
			end
		end
		if (best_len < count) begin
			r.status = ST_NO_SPACE;
			return r;
		end
		run_end = best_start + best_len;
		if (best_start > 0)
			left = model_map[best_start - 1];
		if (run_end < MAP_SIZE)
			right = model_map[run_end];
		color = 2'd1;
		if (left == color || right == color)
			color = 2'd2;
		if (left == color || right == color)
			color = 2'd3;
		for (int i = 0; i < count; i++)
			model_map[best_start + i] = color;
		r.status = ST_OK;
		r.start_index = best_start[9:0];
		r.run_length = count[10:0];
		return r;
	endfunction

	function automatic alloc_result_t predict_free(int idx);
		alloc_result_t r;
		logic [1:0] color;
		int len;
		r = '0;
		len = 0;
		color = model_map[idx];
		if (color == COLOR_FREE || (idx > 0 && model_map[idx - 1] == color)) begin
			r.status = ST_BAD_ARG;
			return r;
		end
		for (int i = idx; i < MAP_SIZE && model_map[i] == color; i++) begin
			model_map[i] = COLOR_FREE;
			len++;
		end
		r.status = ST_OK;
		r.start_index = idx[9:0];
		r.run_length = len[10:0];
		return r;
	endfunction

	task automatic send_request(logic req_op, logic [10:0] count, logic [9:0] idx);
		int gap;
		gap = $urandom_range(0, 8);
		if ($urandom_range(0, 3) == 0)
			gap = 0;
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		op <= req_op;
		block_count <= count;
		block_index <= idx;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
		if (req_op == OP_ALLOC)
			expected_results.push_back(predict_allocate(count));
		else
			expected_results.push_back(predict_free(idx));
	endtask

	task automatic drain_results();
		in_valid <= 1'b0;
		while (expected_results.size() != 0)
			@(posedge clk);
		repeat (20) @(posedge clk);
	endtask

	function automatic logic [9:0] pick_start();
		int starts [$];
		for (int i = 0; i < MAP_SIZE; i++)
			if (model_map[i] != COLOR_FREE && (i == 0 || model_map[i - 1] != model_map[i]))
				starts.push_back(i);
		if (starts.size() == 0)
			return 10'($urandom_range(0, MAP_SIZE - 1));
		return 10'(starts[$urandom_range(0, starts.size() - 1)]);
	endfunction

	task automatic test_directed();
		send_request(OP_FREE, 11'd0, 10'd0);
		send_request(OP_ALLOC, 11'd0, 10'd0);
		send_request(OP_ALLOC, 11'd1025, 10'd0);
		send_request(OP_ALLOC, 11'd2047, 10'd1023);
		send_request(OP_ALLOC, 11'd1024, 10'd0);
		send_request(OP_ALLOC, 11'd1, 10'd0);
		send_request(OP_FREE, 11'd0, 10'd5);
		send_request(OP_FREE, 11'd2047, 10'd0);
		send_request(OP_FREE, 11'd0, 10'd0);
		send_request(OP_ALLOC, 11'd4, 10'd0);
		send_request(OP_ALLOC, 11'd4, 10'd0);
		send_request(OP_ALLOC, 11'd4, 10'd0);
		send_request(OP_FREE, 11'd0, 10'd5);
		send_request(OP_FREE, 11'd0, 10'd4);
		send_request(OP_ALLOC, 11'd2, 10'd0);
		send_request(OP_ALLOC, 11'd1012, 10'd0);
		send_request(OP_ALLOC, 11'd1, 10'd0);
		send_request(OP_FREE, 11'd0, 10'd1023);
		send_request(OP_FREE, 11'd0, 10'd12);
		send_request(OP_ALLOC, 11'd1, 10'd0);
		send_request(OP_FREE, 11'd0, 10'd0);
		send_request(OP_FREE, 11'd0, 10'd8);
		send_request(OP_FREE, 11'd0, 10'd4);
		send_request(OP_FREE, 11'd0, 10'd6);
		drain_results();
	endtask

	task automatic test_random(int n);
		int k;
		for (int i = 0; i < n; i++) begin
			k = $urandom_range(0, 19);
			if (k < 9)
				send_request(OP_ALLOC, 11'($urandom_range(1, 64)), 10'($urandom));
			else if (k < 16)
				send_request(OP_FREE, 11'($urandom), pick_start());
			else if (k < 18)
				send_request(OP_FREE, 11'($urandom), 10'($urandom));
			else
				send_request(OP_ALLOC, 11'($urandom), 10'($urandom));
		end
		drain_results();
	endtask

	task automatic test_backpressure();
		hold_receiver = 1'b1;
		for (int i = 0; i < 6; i++)
			send_request(OP_ALLOC, 11'($urandom_range(1, 16)), 10'($urandom));
		drain_results();
	endtask

	initial begin
		arst_n = 1'b0;
		in_valid = 1'b0;
		op = OP_ALLOC;
		block_count = '0;
		block_index = '0;
		errors = 0;
		hold_receiver = 1'b0;
		for (int i = 0; i < MAP_SIZE; i++)
			model_map[i] = COLOR_FREE;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		test_directed();
		test_random(250);
		test_backpressure();
		test_random(260);
		if (errors == 0)
			$display("colored_run_block_allocator_top_tb: clean");
		else
			$display("colored_run_block_allocator_top_tb: errors");
		$finish;
	end

	initial begin
		int wait_cycles;
		out_stall = 1'b0;
		forever begin
			@(posedge clk);
			if (hold_receiver) begin
				out_stall <= 1'b1;
				repeat (3000) @(posedge clk);
				hold_receiver = 1'b0;
				out_stall <= 1'b0;
			end else if (out_valid && !out_stall) begin
				wait_cycles = $urandom_range(0, 8);
				if ($urandom_range(0, 3) == 0)
					wait_cycles = 0;
				if (wait_cycles > 0) begin
					out_stall <= 1'b1;
					repeat (wait_cycles) @(posedge clk);
					out_stall <= 1'b0;
				end
			end
		end
	end

	always @(posedge clk) begin
		alloc_result_t exp_r;
		if (arst_n && out_valid && !out_stall) begin
			if (expected_results.size() == 0) begin
				$error("result with nothing expected");
				errors++;
			end else begin
				exp_r = expected_results.pop_front();
				if (status !== exp_r.status) begin
					$error("status expected %0d actual %0d", exp_r.status, status);
					errors++;
				end
				if (start_index !== exp_r.start_index) begin
					$error("start_index expected %0d actual %0d",
						exp_r.start_index, start_index);
					errors++;
				end
				if (run_length !== exp_r.run_length) begin
					$error("run_length expected %0d actual %0d",
						exp_r.run_length, run_length);
					errors++;
				end
			end
		end
	end

	always @(posedge clk) begin
		if ((in_valid && !in_stall) || (out_valid && !out_stall))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= WATCH_LIMIT) begin
			$display("colored_run_block_allocator_top_tb: errors");
			$finish;
		end
	end

	initial idle_cycles = 0;

endmodule

FILE: sim.f
hw/rtl/crba_pkg.sv
hw/rtl/crba_mem.sv
hw/rtl/colored_run_block_allocator_top.sv
tb/colored_run_block_allocator_top_tb.sv
